// ===== hw/rtl/box_blur_3x3_edge_aware_defines.svh =====
// assertion macros shared by the blur modules
`ifndef BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds in the same cycle as the trigger
`define BB3EA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blur check failed: same-cycle implication");

// condition holds in the cycle after the trigger
`define BB3EA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blur check failed: next-cycle implication");

`else

`define BB3EA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BB3EA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/bb3ea_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bb3ea_pkg;

    // configuration port
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // item kinds
    localparam logic MODE_PIXEL = 1'b0;

    // row counter covers the drain rows past the frame
    localparam int ROW_W = CFG_W + 1;

    // arithmetic widths
    localparam int TAPS        = 9;
    localparam int CNT_W       = 4;
    localparam int SUM_W       = 12;
    localparam int NUM_W       = SUM_W + 1;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = NUM_W + RECIP_W;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // one window column, top row first
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    // one line store entry: two rows of the same column
    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_word_t;

    // classified item handed from front to back
    typedef struct packed {
        pixel_t           pix;
        logic             emit;
        logic             left_ok;
        logic             right_ok;
        logic             top_ok;
        logic             bot_ok;
        logic [CNT_W-1:0] count;
        logic             last;
    } item_t;

    // ceil(2^19 / count): scaled reciprocal of 2*count
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        unique case (cnt)
            4'd1:    m = 20'd524288;
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174763;
            4'd4:    m = 20'd131072;
            4'd5:    m = 20'd104858;
            4'd6:    m = 20'd87382;
            4'd7:    m = 20'd74899;
            4'd8:    m = 20'd65536;
            4'd9:    m = 20'd58255;
            default: m = '0;
        endcase
        return m;
    endfunction

    // (2*sum + count) / (2*count), exact for sums of up to nine bytes
    function automatic logic [7:0] mean_round(input logic [SUM_W-1:0] sum,
                                              input logic [CNT_W-1:0] cnt);
        logic [NUM_W-1:0]  num;
        logic [PROD_W-1:0] prod;
        num  = {sum, 1'b0} + NUM_W'(cnt);
        prod = PROD_W'(num) * PROD_W'(recip(cnt));
        return prod[RECIP_SHIFT +: 8];
    endfunction

    // sum of the window taps that lie inside the frame
    function automatic logic [SUM_W-1:0] masked_sum(input logic [TAPS-1:0][7:0] v,
                                                    input logic [TAPS-1:0] m);
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            if (m[i])
            begin
                acc = acc + SUM_W'(v[i]);
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bb3ea_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bb3ea_queue
    import bb3ea_pkg::*;
#(
    parameter int W = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  wire logic [W-1:0] push_data,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output logic [W-1:0]      pop_data
);

    logic [W-1:0]      slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              push_fire;
    logic              pop_fire;

    // handshake
    assign push_ready = (fill_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // pointers wrap at the power-of-two depth
    always_comb
    begin
        wr_ptr_next = push_fire ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (QPTR_W + 1)'(push_fire) - (QPTR_W + 1)'(pop_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bb3ea_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_3x3_edge_aware_defines.svh"

module bb3ea_front
    import bb3ea_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int AW        = 11
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 mode,
    input  wire logic [7:0]           red_in,
    input  wire logic [7:0]           green_in,
    input  wire logic [7:0]           blue_in,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output logic [AW-1:0]             push_col,
    output item_t                     push_item
);

    localparam int CMP_W = (AW > CFG_W) ? AW : CFG_W;
    localparam logic [CFG_W-1:0] W_RESET =
        (RESET_WIDTH > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : CFG_W'(RESET_WIDTH);

    logic [CFG_W-1:0] w_eff_reg, w_eff_next;
    logic [CFG_W-1:0] h_eff_reg, h_eff_next;
    logic [AW-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [AW-1:0]    q_col_reg, q_col_next;
    logic [CFG_W-1:0] q_row_reg, q_row_next;

    logic             cfg_fire;
    logic             push_fire;
    logic [CFG_W-1:0] w_clamped;
    logic [CFG_W-1:0] h_clamped;
    logic [CFG_W-1:0] h_last;
    logic [CMP_W-1:0] w_last;
    logic             col_end;
    logic             q_col_end;
    logic             pix_slot;
    logic [1:0]       n_cols;
    logic [1:0]       n_rows;
    item_t            item;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign push_fire  = in_valid && push_ready;
    assign push_col   = in_col_reg;
    assign push_item  = item;

    // register values as used: zero acts as one, width capped at the store depth
    always_comb
    begin
        if (cfg_data == '0)
        begin
            w_clamped = CFG_W'(1);
        end
        else if (int'(cfg_data) > MAX_WIDTH)
        begin
            w_clamped = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            w_clamped = cfg_data;
        end
        h_clamped = (cfg_data == '0) ? CFG_W'(1) : cfg_data;
    end

    // position of the incoming word and of the pending result
    always_comb
    begin
        w_last    = CMP_W'(w_eff_reg) - CMP_W'(1);
        h_last    = h_eff_reg - CFG_W'(1);
        col_end   = (CMP_W'(in_col_reg) == w_last);
        q_col_end = (CMP_W'(q_col_reg) == w_last);
        pix_slot  = (in_row_reg < ROW_W'(h_eff_reg));
    end

    // classify the word
    always_comb
    begin
        item.pix      = (pix_slot && mode == MODE_PIXEL) ? {red_in, green_in, blue_in} : '0;
        item.emit     = (in_row_reg > ROW_W'(1)) ||
                        (in_row_reg == ROW_W'(1) && in_col_reg != '0);
        item.left_ok  = (q_col_reg != '0);
        item.right_ok = !q_col_end;
        item.top_ok   = (q_row_reg != '0);
        item.bot_ok   = (q_row_reg != h_last);
        item.last     = q_col_end && (q_row_reg == h_last);
        n_cols        = 2'd1 + 2'(item.left_ok) + 2'(item.right_ok);
        n_rows        = 2'd1 + 2'(item.top_ok) + 2'(item.bot_ok);
        item.count    = CNT_W'(n_cols) * CNT_W'(n_rows);
    end

    // counter and register updates
    always_comb
    begin
        w_eff_next  = w_eff_reg;
        h_eff_next  = h_eff_reg;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        q_col_next  = q_col_reg;
        q_row_next  = q_row_reg;
        if (cfg_fire)
        begin
            priority if (cfg_index == REG_FRAME_WIDTH)
            begin
                w_eff_next  = w_clamped;
                in_col_next = '0;
                in_row_next = '0;
                q_col_next  = '0;
                q_row_next  = '0;
            end
            else if (cfg_index == REG_FRAME_HEIGHT)
            begin
                h_eff_next  = h_clamped;
                in_col_next = '0;
                in_row_next = '0;
                q_col_next  = '0;
                q_row_next  = '0;
            end
            else
            begin
                w_eff_next = w_eff_reg;
            end
        end
        else if (push_fire)
        begin
            if (item.emit && item.last)
            begin
                in_col_next = '0;
                in_row_next = '0;
                q_col_next  = '0;
                q_row_next  = '0;
            end
            else
            begin
                if (col_end)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + AW'(1);
                end
                if (item.emit)
                begin
                    if (q_col_end)
                    begin
                        q_col_next = '0;
                        q_row_next = q_row_reg + CFG_W'(1);
                    end
                    else
                    begin
                        q_col_next = q_col_reg + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg  <= W_RESET;
            h_eff_reg  <= CFG_W'(RESET_HEIGHT);
            in_col_reg <= '0;
            in_row_reg <= '0;
            q_col_reg  <= '0;
            q_row_reg  <= '0;
        end
        else
        begin
            w_eff_reg  <= w_eff_next;
            h_eff_reg  <= h_eff_next;
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            q_col_reg  <= q_col_next;
            q_row_reg  <= q_row_next;
        end
    end

    // the flagged result closes the frame
    `BB3EA_ASSERT_NEXT(a_frame_restart, clk, rst_n, push_fire && item.emit && item.last, in_col_reg == '0 && in_row_reg == '0)
    // the result position never runs ahead of the input position
    `BB3EA_ASSERT_IMPLIES(a_result_lags_input, clk, rst_n, 1'b1, ROW_W'(q_row_reg) <= in_row_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/bb3ea_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_3x3_edge_aware_defines.svh"

module bb3ea_back
    import bb3ea_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int AW        = 11
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire logic [AW-1:0] pop_col,
    input  wire item_t         pop_item,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out,
    output logic               frame_last
);

    // line store: upper and middle rows share one address
    line_word_t line_mem_reg [MAX_WIDTH];

    // stage 1: line store read
    logic             s1_v_reg, s1_v_next;
    logic [AW-1:0]    s1_col_reg;
    item_t            s1_item_reg;
    line_word_t       rd_word_reg;
    logic             hit_reg, hit_next;
    line_word_t       hit_word_reg;

    // window, oldest column first
    column_t          win_reg [3];

    // stage 2: window sum
    logic             s2_v_reg, s2_v_next;
    item_t            s2_item_reg;

    // stage 3: rounding divide
    logic             s3_v_reg, s3_v_next;
    logic [SUM_W-1:0] sum_red_reg, sum_green_reg, sum_blue_reg;
    logic [CNT_W-1:0] s3_count_reg;
    logic             s3_last_reg;

    // output register
    logic             out_v_reg, out_v_next;
    pixel_t           res_reg;
    logic             last_reg;

    logic             pop_fire;
    logic             out_fire;
    logic             s1_adv, s1_free;
    logic             s2_adv, s2_free;
    logic             s3_adv, s3_free;
    logic             s4_free;
    line_word_t       cur_word;
    line_word_t       wr_word;
    column_t          new_col;
    logic [2:0]       col_ok;
    logic [2:0]       row_ok;
    logic [TAPS-1:0]       tap_mask;
    logic [TAPS-1:0][7:0]  tap_red, tap_green, tap_blue;
    pixel_t           mean;

    // stage flow
    always_comb
    begin
        out_fire = out_v_reg && out_ready;
        s4_free  = !out_v_reg || out_ready;
        s3_adv   = s3_v_reg && s4_free;
        s3_free  = !s3_v_reg || s3_adv;
        s2_adv   = s2_v_reg && (!s2_item_reg.emit || s3_free);
        s2_free  = !s2_v_reg || s2_adv;
        s1_adv   = s1_v_reg && s2_free;
        s1_free  = !s1_v_reg || s1_adv;
        pop_fire = pop_valid && s1_free;
    end

    assign pop_ready = s1_free;

    // stored rows, with bypass of a write to the address read in the same cycle
    always_comb
    begin
        cur_word       = hit_reg ? hit_word_reg : rd_word_reg;
        new_col.top    = cur_word.upper;
        new_col.mid    = cur_word.middle;
        new_col.bot    = s1_item_reg.pix;
        wr_word.upper  = cur_word.middle;
        wr_word.middle = s1_item_reg.pix;
        hit_next       = pop_fire ? (s1_adv && pop_col == s1_col_reg) : hit_reg;
    end

    // taps inside the frame
    always_comb
    begin
        col_ok = {s2_item_reg.right_ok, 1'b1, s2_item_reg.left_ok};
        row_ok = {s2_item_reg.bot_ok, 1'b1, s2_item_reg.top_ok};
        for (int c = 0; c < 3; c++)
        begin
            tap_red[c*3]       = win_reg[c].top.red;
            tap_red[c*3+1]     = win_reg[c].mid.red;
            tap_red[c*3+2]     = win_reg[c].bot.red;
            tap_green[c*3]     = win_reg[c].top.green;
            tap_green[c*3+1]   = win_reg[c].mid.green;
            tap_green[c*3+2]   = win_reg[c].bot.green;
            tap_blue[c*3]      = win_reg[c].top.blue;
            tap_blue[c*3+1]    = win_reg[c].mid.blue;
            tap_blue[c*3+2]    = win_reg[c].bot.blue;
            for (int r = 0; r < 3; r++)
            begin
                tap_mask[c*3+r] = col_ok[c] && row_ok[r];
            end
        end
    end

    // rounded means
    always_comb
    begin
        mean.red   = mean_round(sum_red_reg, s3_count_reg);
        mean.green = mean_round(sum_green_reg, s3_count_reg);
        mean.blue  = mean_round(sum_blue_reg, s3_count_reg);
    end

    // valid bits
    always_comb
    begin
        s1_v_next  = pop_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_v_reg);
        s2_v_next  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_v_reg);
        s3_v_next  = (s2_adv && s2_item_reg.emit) ? 1'b1 : (s3_adv ? 1'b0 : s3_v_reg);
        out_v_next = s3_adv ? 1'b1 : (out_fire ? 1'b0 : out_v_reg);
    end

    // control and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            hit_reg   <= 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                win_reg[c] <= '0;
            end
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            s3_v_reg  <= s3_v_next;
            out_v_reg <= out_v_next;
            hit_reg   <= hit_next;
            if (s1_adv)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= new_col;
            end
        end
    end

    // line store, read registered
    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            rd_word_reg  <= line_mem_reg[pop_col];
            hit_word_reg <= wr_word;
        end
        if (s1_adv)
        begin
            line_mem_reg[s1_col_reg] <= wr_word;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            s1_col_reg  <= pop_col;
            s1_item_reg <= pop_item;
        end
        if (s1_adv)
        begin
            s2_item_reg <= s1_item_reg;
        end
        if (s2_adv && s2_item_reg.emit)
        begin
            sum_red_reg   <= masked_sum(tap_red, tap_mask);
            sum_green_reg <= masked_sum(tap_green, tap_mask);
            sum_blue_reg  <= masked_sum(tap_blue, tap_mask);
            s3_count_reg  <= s2_item_reg.count;
            s3_last_reg   <= s2_item_reg.last;
        end
        if (s3_adv)
        begin
            res_reg  <= mean;
            last_reg <= s3_last_reg;
        end
    end

    assign out_valid  = out_v_reg;
    assign red_out    = res_reg.red;
    assign green_out  = res_reg.green;
    assign blue_out   = res_reg.blue;
    assign frame_last = last_reg;

    // every result covers at least its own pixel
    `BB3EA_ASSERT_IMPLIES(a_count_nonzero, clk, rst_n, s3_v_reg, s3_count_reg != '0 && s3_count_reg <= CNT_W'(TAPS))

endmodule

`default_nettype wire

// ===== hw/rtl/box_blur_3x3_edge_aware.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  payload                                    taken when
// cfg      in   cfg_index, cfg_data                        cfg_valid && cfg_ready
// in       in   mode, red_in, green_in, blue_in            in_valid && in_ready
// out      out  red_out, green_out, blue_out, frame_last   out_valid && out_ready
//
// One word per clock while out_ready holds: each word does one line store read and
// one write, on separate ports, and every stage moves on in the cycle it is freed.
// A word's result passes the read, sum and divide stages to the output register.
// Reset clears counters, window and valid bits; the line store is not cleared and
// no clearing pass runs, so words are taken from the first cycle after reset.
// A stalled output fills the pipeline, then the four-entry queue, then drops in_ready.

module box_blur_3x3_edge_aware
    import bb3ea_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 mode,
    input  wire logic [7:0]           red_in,
    input  wire logic [7:0]           green_in,
    input  wire logic [7:0]           blue_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                red_out,
    output logic [7:0]                green_out,
    output logic [7:0]                blue_out,
    output logic                      frame_last
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int IW = $bits(item_t);
    localparam int QW = AW + IW;

    logic          push_valid;
    logic          push_ready;
    logic [AW-1:0] push_col;
    item_t         push_item;
    logic [QW-1:0] push_data;
    logic          pop_valid;
    logic          pop_ready;
    logic [QW-1:0] pop_data;
    logic [AW-1:0] pop_col;
    item_t         pop_item;

    // classification and frame counters
    bb3ea_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_col   (push_col),
        .push_item  (push_item)
    );

    // pack column and item for the queue
    assign push_data = {push_col, push_item};
    assign pop_col   = pop_data[QW-1 -: AW];
    assign pop_item  = item_t'(pop_data[IW-1:0]);

    bb3ea_queue #(
        .W (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // line store, window and arithmetic
    bb3ea_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_col    (pop_col),
        .pop_item   (pop_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .frame_last (frame_last)
    );

endmodule

`default_nettype wire
